// File: rtl/core/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
package cfr_pkg;

	// Frame layout
	localparam int FRAME_BYTES = 7;
	localparam int COUNT_W     = 3;

	localparam logic [7:0] START_RESET     = 8'd170;
	localparam logic [7:0] END_FIRST_RESET = 8'd13;
	localparam logic [7:0] END_SECOND_RESET = 8'd10;

	// Byte positions inside a frame
	localparam int POS_START  = 0;
	localparam int POS_SUM    = 1;
	localparam int POS_DIR    = 2;
	localparam int POS_ANGLE  = 3;
	localparam int POS_POSE   = 4;
	localparam int POS_END1   = 5;
	localparam int POS_END2   = 6;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_START_MARKER      = 2'd0,
		REG_END_MARKER_FIRST  = 2'd1,
		REG_END_MARKER_SECOND = 2'd2,
		REG_UNUSED            = 2'd3
	} reg_index_t;

	// Item kinds
	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_IDLE = 1'b1
	} req_kind_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic push;
		logic clear;
	} store_ctrl_t;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker_first;
		logic [7:0] end_marker_second;
	} markers_t;

	typedef struct packed {
		logic       frame_valid;
		logic       turn_left;
		logic [7:0] steer_angle;
		logic       squat;
	} result_t;

endpackage

// File: rtl/core/cfr_frame_store.sv
// Seven-byte frame buffer with fill count; bytes past the end are dropped.
module cfr_frame_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfr_pkg::store_ctrl_t ctrl,
	input  logic [7:0]           data,
	output cfr_pkg::frame_t      frame
);

	cfr_pkg::frame_t                frame_q;
	logic [cfr_pkg::COUNT_W-1:0]    count_q;
	logic                           has_room;

	assign has_room = (count_q < cfr_pkg::COUNT_W'(cfr_pkg::FRAME_BYTES));

	// Store and count; a clear returns everything to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			frame_q <= '0;
			count_q <= '0;
		end else if (ctrl.push && has_room) begin
			for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
				if (count_q == cfr_pkg::COUNT_W'(i)) begin
					frame_q[i] <= data;
				end
			end
			count_q <= count_q + cfr_pkg::COUNT_W'(1);
		end
	end

	assign frame = frame_q;

endmodule

// File: rtl/core/cfr_frame_check.sv
// Frame check and result register with output handshake.
module cfr_frame_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cfr_pkg::frame_t   frame,
	input  cfr_pkg::markers_t markers,
	input  logic              out_stall,
	output logic              ready,
	output logic              out_valid,
	output cfr_pkg::result_t  result
);

	logic [7:0]       sum;
	logic             ok;
	cfr_pkg::result_t res_d;
	cfr_pkg::result_t res_q;
	logic             valid_q;

	// Checksum over direction, angle and posture bytes
	assign sum = frame[cfr_pkg::POS_DIR] + frame[cfr_pkg::POS_ANGLE]
	           + frame[cfr_pkg::POS_POSE];

	assign ok = (frame[cfr_pkg::POS_START] == markers.start_marker)
	         && (frame[cfr_pkg::POS_SUM]   == sum)
	         && (frame[cfr_pkg::POS_END1]  == markers.end_marker_first)
	         && (frame[cfr_pkg::POS_END2]  == markers.end_marker_second);

	// Command fields are zero for a bad frame
	always_comb begin
		res_d.frame_valid = ok;
		res_d.turn_left   = ok && (frame[cfr_pkg::POS_DIR] == 8'h00);
		res_d.steer_angle = ok ? frame[cfr_pkg::POS_ANGLE] : 8'h00;
		res_d.squat       = ok && (frame[cfr_pkg::POS_POSE] == 8'h00);
	end

	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign result    = res_q;

endmodule

// File: rtl/core/command_frame_receiver.sv
// Top level of the command frame receiver.
// Takes one item per cycle while in_stall is low. A byte item goes through
// the input register and lands in the frame buffer the next cycle; an idle
// item is checked against the buffer while it sits in the input register,
// and its result is loaded into the output register, while the buffer is
// cleared, once that register can take it. Byte items give no result. Only
// a stalled output register holds back input.
module command_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_valid,
	output logic       turn_left,
	output logic [7:0] steer_angle,
	output logic       squat,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfr_pkg::markers_t    markers_q;
	logic                 valid_s1;
	logic                 type_s1;
	logic [7:0]           byte_s1;
	logic                 res_ready;
	logic                 go_s1;
	cfr_pkg::store_ctrl_t store_ctrl;
	cfr_pkg::frame_t      frame;
	cfr_pkg::result_t     result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markers_q.start_marker      <= cfr_pkg::START_RESET;
			markers_q.end_marker_first  <= cfr_pkg::END_FIRST_RESET;
			markers_q.end_marker_second <= cfr_pkg::END_SECOND_RESET;
		end else if (cfg_we) begin
			unique case (cfr_pkg::reg_index_t'(cfg_index))
				cfr_pkg::REG_START_MARKER:      markers_q.start_marker      <= cfg_data;
				cfr_pkg::REG_END_MARKER_FIRST:  markers_q.end_marker_first  <= cfg_data;
				cfr_pkg::REG_END_MARKER_SECOND: markers_q.end_marker_second <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 moves on unless it holds an idle item and the result is blocked
	assign go_s1    = !valid_s1 || (type_s1 == cfr_pkg::REQ_BYTE) || res_ready;
	assign in_stall = !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && in_valid) begin
			type_s1 <= req_type;
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		store_ctrl.push  = valid_s1 && (type_s1 == cfr_pkg::REQ_BYTE);
		store_ctrl.clear = valid_s1 && (type_s1 == cfr_pkg::REQ_IDLE) && res_ready;
	end

	cfr_frame_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (store_ctrl),
		.data   (byte_s1),
		.frame  (frame)
	);

	cfr_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (store_ctrl.clear),
		.frame     (frame),
		.markers   (markers_q),
		.out_stall (out_stall),
		.ready     (res_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign frame_valid = result.frame_valid;
	assign turn_left   = result.turn_left;
	assign steer_angle = result.steer_angle;
	assign squat       = result.squat;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the command frame receiver: frame predictor, scoreboard, drivers.

// Predicts the decoded command of each frame and checks the block's results in order
class frame_checker;
	logic [7:0]       store [cfr_pkg::FRAME_BYTES];
	int unsigned      fill;
	cfr_pkg::markers_t markers;
	cfr_pkg::result_t expected_q [$];
	int               errors;

	function new();
		markers.start_marker      = cfr_pkg::START_RESET;
		markers.end_marker_first  = cfr_pkg::END_FIRST_RESET;
		markers.end_marker_second = cfr_pkg::END_SECOND_RESET;
		errors = 0;
		clear_store();
	endfunction

	function void clear_store();
		foreach (store[i]) store[i] = 8'h00;
		fill = 0;
	endfunction

	function void set_marker(cfr_pkg::reg_index_t idx, logic [7:0] value);
		case (idx)
			cfr_pkg::REG_START_MARKER:      markers.start_marker = value;
			cfr_pkg::REG_END_MARKER_FIRST:  markers.end_marker_first = value;
			cfr_pkg::REG_END_MARKER_SECOND: markers.end_marker_second = value;
			default: ;
		endcase
	endfunction

	// Accepted input item: store a byte, or check the frame on an idle event
	function void note_item(cfr_pkg::req_kind_t kind, logic [7:0] rx);
		logic [7:0]       sum;
		logic             ok;
		cfr_pkg::result_t res;
		if (kind == cfr_pkg::REQ_BYTE) begin
			// overlong frames: extra bytes are dropped
			if (fill < cfr_pkg::FRAME_BYTES) begin
				store[fill] = rx;
				fill++;
			end
		end else begin
			sum = store[cfr_pkg::POS_DIR] + store[cfr_pkg::POS_ANGLE]
				+ store[cfr_pkg::POS_POSE];
			ok = (store[cfr_pkg::POS_START] == markers.start_marker)
				&& (store[cfr_pkg::POS_SUM] == sum)
				&& (store[cfr_pkg::POS_END1] == markers.end_marker_first)
				&& (store[cfr_pkg::POS_END2] == markers.end_marker_second);
			res.frame_valid = ok;
			res.turn_left   = ok && (store[cfr_pkg::POS_DIR] == 8'h00);
			res.steer_angle = ok ? store[cfr_pkg::POS_ANGLE] : 8'h00;
			res.squat       = ok && (store[cfr_pkg::POS_POSE] == 8'h00);
			expected_q.push_back(res);
			clear_store();
		end
	endfunction

	function void report(string what, cfr_pkg::result_t exp_r, cfr_pkg::result_t got);
		errors++;
		if (errors <= 10)
			$display({"MISMATCH %s: expected valid=%0b left=%0b angle=%0d squat=%0b,",
				" got valid=%0b left=%0b angle=%0d squat=%0b"},
				what, exp_r.frame_valid, exp_r.turn_left, exp_r.steer_angle, exp_r.squat,
				got.frame_valid, got.turn_left, got.steer_angle, got.squat);
	endfunction

	// Accepted result: compare with the oldest predicted command
	function void check_result(cfr_pkg::result_t got);
		cfr_pkg::result_t exp_r;
		if (expected_q.size() == 0) begin
			exp_r = '0;
			report("unexpected result", exp_r, got);
		end else begin
			exp_r = expected_q.pop_front();
			if (got.frame_valid !== exp_r.frame_valid || got.turn_left !== exp_r.turn_left
				|| got.steer_angle !== exp_r.steer_angle || got.squat !== exp_r.squat)
				report("field", exp_r, got);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = 2;
	localparam int IDLE_LIMIT = 1000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       req_type = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       frame_valid;
	logic       turn_left;
	logic [7:0] steer_angle;
	logic       squat;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'h00;

	frame_checker sb = new();
	int  items = 0;
	bit  calm = 1'b0;
	int  stall_left = 0;
	int  quiet_cycles = 0;

	command_frame_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_valid(frame_valid), .turn_left(turn_left),
		.steer_angle(steer_angle), .squat(squat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver back-pressure in short random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 3) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{frame_valid, turn_left, steer_angle, squat});
	end

	// Watchdog on cycles without any handshake
	initial begin
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Send one item, with an occasional gap before it
	task automatic send_item(cfr_pkg::req_kind_t kind, logic [7:0] rx);
		if (!calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		rx_byte  <= rx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(kind, rx);
		items++;
		if (items > 380) calm = 1'b1;
	endtask

	// Stop sending and wait until every expected command has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_markers(logic [7:0] s, logic [7:0] e1, logic [7:0] e2);
		cfr_pkg::reg_index_t idx [4];
		logic [7:0] val [4];
		idx = '{cfr_pkg::REG_START_MARKER, cfr_pkg::REG_END_MARKER_FIRST,
			cfr_pkg::REG_END_MARKER_SECOND, cfr_pkg::REG_UNUSED};
		val = '{s, e1, e2, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_marker(idx[i], val[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(logic [7:0] fb [], int len);
		for (int i = 0; i < len; i++) send_item(cfr_pkg::REQ_BYTE, fb[i]);
		send_item(cfr_pkg::REQ_IDLE, 8'($urandom));
	endtask

	// Mostly well-formed frames with random content, some broken or noise
	task automatic send_random_frame();
		logic [7:0] fb [];
		int len;
		int mode;
		int k;
		fb = new[9];
		mode = $urandom_range(0, 9);
		fb[cfr_pkg::POS_START] = sb.markers.start_marker;
		fb[cfr_pkg::POS_DIR]   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
		fb[cfr_pkg::POS_ANGLE] = 8'($urandom);
		fb[cfr_pkg::POS_POSE]  = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
		fb[cfr_pkg::POS_SUM]   = fb[cfr_pkg::POS_DIR] + fb[cfr_pkg::POS_ANGLE]
			+ fb[cfr_pkg::POS_POSE];
		fb[cfr_pkg::POS_END1]  = sb.markers.end_marker_first;
		fb[cfr_pkg::POS_END2]  = sb.markers.end_marker_second;
		fb[7] = 8'($urandom);
		fb[8] = 8'($urandom);
		len = cfr_pkg::FRAME_BYTES;
		if (mode == 7) begin
			k = $urandom_range(0, cfr_pkg::FRAME_BYTES - 1);
			fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
		end else if (mode == 8) begin
			len = $urandom_range(0, 9);
		end else if (mode == 9) begin
			foreach (fb[i]) fb[i] = 8'($urandom);
			len = $urandom_range(0, 9);
		end
		send_frame(fb, len);
	endtask

	initial begin
		logic [7:0] fb [];
		int target;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: wrapping checksum, non-zero direction and posture
		fb = {8'hAA, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'h0D, 8'h0A};
		send_frame(fb, 7);
		// Overlong frame, left turn and squat; trailing bytes dropped
		fb = {8'hAA, 8'h2A, 8'h00, 8'h2A, 8'h00, 8'h0D, 8'h0A, 8'h55, 8'h33};
		send_frame(fb, 9);
		// Short frame, then an empty one
		fb = {8'hAA, 8'h00};
		send_frame(fb, 2);
		send_item(cfr_pkg::REQ_IDLE, 8'hFF);

		// Random phases over several marker settings
		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				1: write_markers(8'h00, 8'h00, 8'h00);
				2: write_markers(8'hFF, 8'hFF, 8'hFF);
				3: write_markers(8'($urandom), 8'($urandom), 8'($urandom));
				4: write_markers(cfr_pkg::START_RESET, cfr_pkg::END_FIRST_RESET,
					cfr_pkg::END_SECOND_RESET);
				default: ;
			endcase
			target = 22 + (phase + 1) * 86;
			while (items < target) send_random_frame();
		end

		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
